/* hw/rtl/nrd_pkg.sv */
// ----------------------------------------------------------------------------
// nrd_pkg
// Shared constants, entry and operation types for the nearest resource
// dispatcher.
// ----------------------------------------------------------------------------
package nrd_pkg;

    localparam int RIDER_DEPTH  = 16;
    localparam int SERVER_SLOTS = 16;

    localparam int RIDX_W = $clog2(RIDER_DEPTH);
    localparam int RCNT_W = $clog2(RIDER_DEPTH + 1);
    localparam int SIDX_W = $clog2(SERVER_SLOTS);
    localparam int SCNT_W = $clog2(SERVER_SLOTS + 1);

    localparam int COORD_W  = 16;
    localparam int CONN_W   = 8;
    localparam int STATUS_W = 2;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 32;
    localparam int DIST_W   = SQ_W + 1;

    localparam logic CMD_RIDER  = 1'b0;
    localparam logic CMD_SERVER = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_STORED  = 2'd0,
        STATUS_PAIRED  = 2'd1,
        STATUS_DROPPED = 2'd2
    } status_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CONN_W-1:0]  conn;
    } entry_t;

    typedef struct packed {
        logic   is_server;
        entry_t entry;
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHECK,
        BK_SCAN,
        BK_SHIFT,
        BK_RESP
    } back_state_t;

endpackage

/* hw/rtl/nrd_front.sv */
// ----------------------------------------------------------------------------
// nrd_front
// Input stage: takes request transfers, decodes the command and registers
// the item as an operation for the back end queue.
// ----------------------------------------------------------------------------
module nrd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic signed [nrd_pkg::COORD_W-1:0] pos_x,
    input  logic signed [nrd_pkg::COORD_W-1:0] pos_y,
    input  logic [nrd_pkg::CONN_W-1:0]   conn_id,
    output logic                         op_valid,
    input  logic                         op_ready,
    output nrd_pkg::op_t                 op
);

    logic         op_valid_reg;
    nrd_pkg::op_t op_reg;

    assign in_ready = !op_valid_reg || op_ready;
    assign op_valid = op_valid_reg;
    assign op       = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            op_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg.is_server  <= (command == nrd_pkg::CMD_SERVER);
            op_reg.entry.x    <= pos_x;
            op_reg.entry.y    <= pos_y;
            op_reg.entry.conn <= conn_id;
        end
    end

endmodule

/* hw/rtl/nrd_queue.sv */
// ----------------------------------------------------------------------------
// nrd_queue
// Short operation queue between the front and back ends so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module nrd_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  nrd_pkg::op_t push_op,
    output logic         pop_valid,
    input  logic         pop_ready,
    output nrd_pkg::op_t pop_op
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    nrd_pkg::op_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != (PTR_W + 1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* hw/rtl/nrd_back.sv */
// ----------------------------------------------------------------------------
// nrd_back
// Execution stage: rider FIFO, server list, nearest-server scan, list
// compaction and the result output register.
// ----------------------------------------------------------------------------
module nrd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         op_valid,
    output logic                         op_ready,
    input  nrd_pkg::op_t                 op,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [nrd_pkg::STATUS_W-1:0] status,
    output logic [nrd_pkg::CONN_W-1:0]   server_conn,
    output logic [nrd_pkg::CONN_W-1:0]   rider_conn,
    output logic signed [nrd_pkg::COORD_W-1:0] rider_x,
    output logic signed [nrd_pkg::COORD_W-1:0] rider_y
);

    // server list kept oldest at slot 0, newest at count-1
    nrd_pkg::entry_t rider_mem [nrd_pkg::RIDER_DEPTH];
    nrd_pkg::entry_t srv_mem   [nrd_pkg::SERVER_SLOTS];

    nrd_pkg::back_state_t state_reg, state_next;

    logic [nrd_pkg::RIDX_W-1:0] rider_head_reg, rider_head_next;
    logic [nrd_pkg::RIDX_W-1:0] rider_tail_reg, rider_tail_next;
    logic [nrd_pkg::RCNT_W-1:0] rider_count_reg, rider_count_next;
    logic [nrd_pkg::SCNT_W-1:0] server_count_reg, server_count_next;

    nrd_pkg::entry_t rider_reg;
    nrd_pkg::entry_t srv_rd_reg;
    logic            rider_we;
    logic            rider_rd_en;
    logic            srv_we;
    logic [nrd_pkg::SIDX_W-1:0] srv_waddr;
    logic [nrd_pkg::SIDX_W-1:0] srv_raddr;
    nrd_pkg::entry_t srv_wdata;

    logic [nrd_pkg::SCNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic                       scan_issue;
    logic                       s1_valid_reg;
    logic [nrd_pkg::SIDX_W-1:0] s1_idx_reg;
    logic                       s2_valid_reg;
    logic [nrd_pkg::SIDX_W-1:0] s2_idx_reg;
    logic [nrd_pkg::CONN_W-1:0] s2_conn_reg;
    logic [nrd_pkg::SQ_W-1:0]   sqx_reg;
    logic [nrd_pkg::SQ_W-1:0]   sqy_reg;

    logic signed [nrd_pkg::DIFF_W-1:0]   dx;
    logic signed [nrd_pkg::DIFF_W-1:0]   dy;
    logic signed [2*nrd_pkg::DIFF_W-1:0] prod_x;
    logic signed [2*nrd_pkg::DIFF_W-1:0] prod_y;
    logic [nrd_pkg::DIST_W-1:0]          sq_sum;

    logic                       best_clear;
    logic                       best_valid_reg;
    logic [nrd_pkg::DIST_W-1:0] best_d_reg;
    logic [nrd_pkg::SIDX_W-1:0] best_idx_reg;
    logic [nrd_pkg::CONN_W-1:0] best_conn_reg;

    logic [nrd_pkg::SCNT_W-1:0] sh_idx_reg, sh_idx_next;
    logic [nrd_pkg::SCNT_W-1:0] sh_prev;
    logic                       sh_issue;
    logic                       sh_w_valid_reg;
    logic [nrd_pkg::SIDX_W-1:0] sh_w_addr_reg;

    nrd_pkg::status_t res_status_reg, res_status_next;
    logic             out_load;

    logic                         out_valid_reg;
    logic [nrd_pkg::STATUS_W-1:0] status_reg;
    logic [nrd_pkg::CONN_W-1:0]   server_conn_reg;
    logic [nrd_pkg::CONN_W-1:0]   rider_conn_reg;
    logic [nrd_pkg::COORD_W-1:0]  rider_x_reg;
    logic [nrd_pkg::COORD_W-1:0]  rider_y_reg;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign server_conn = server_conn_reg;
    assign rider_conn  = rider_conn_reg;
    assign rider_x     = rider_x_reg;
    assign rider_y     = rider_y_reg;

    assign sh_prev = sh_idx_reg - nrd_pkg::SCNT_W'(1);

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        op_ready          = 1'b0;
        rider_we          = 1'b0;
        rider_rd_en       = 1'b0;
        srv_we            = 1'b0;
        srv_waddr         = '0;
        srv_wdata         = op.entry;
        srv_raddr         = '0;
        rider_head_next   = rider_head_reg;
        rider_tail_next   = rider_tail_reg;
        rider_count_next  = rider_count_reg;
        server_count_next = server_count_reg;
        scan_cnt_next     = scan_cnt_reg;
        scan_issue        = 1'b0;
        sh_idx_next       = sh_idx_reg;
        sh_issue          = 1'b0;
        best_clear        = 1'b0;
        res_status_next   = res_status_reg;
        out_load          = 1'b0;

        case (state_reg)
            nrd_pkg::BK_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    if (!op.is_server)
                    begin
                        if (rider_count_reg == nrd_pkg::RCNT_W'(nrd_pkg::RIDER_DEPTH))
                        begin
                            res_status_next = nrd_pkg::STATUS_DROPPED;
                            state_next      = nrd_pkg::BK_RESP;
                        end
                        else
                        begin
                            rider_we         = 1'b1;
                            rider_tail_next  =
                                (rider_tail_reg == nrd_pkg::RIDX_W'(nrd_pkg::RIDER_DEPTH - 1))
                                ? '0 : rider_tail_reg + 1'b1;
                            rider_count_next = rider_count_reg + 1'b1;
                            state_next       = nrd_pkg::BK_CHECK;
                        end
                    end
                    else
                    begin
                        if (server_count_reg == nrd_pkg::SCNT_W'(nrd_pkg::SERVER_SLOTS))
                        begin
                            res_status_next = nrd_pkg::STATUS_DROPPED;
                            state_next      = nrd_pkg::BK_RESP;
                        end
                        else
                        begin
                            srv_we            = 1'b1;
                            srv_waddr         = server_count_reg[nrd_pkg::SIDX_W-1:0];
                            server_count_next = server_count_reg + 1'b1;
                            state_next        = nrd_pkg::BK_CHECK;
                        end
                    end
                end
            end

            nrd_pkg::BK_CHECK:
            begin
                if (rider_count_reg == '0 || server_count_reg == '0)
                begin
                    res_status_next = nrd_pkg::STATUS_STORED;
                    state_next      = nrd_pkg::BK_RESP;
                end
                else
                begin
                    // pop the oldest rider; its entry lands in rider_reg
                    rider_rd_en      = 1'b1;
                    rider_head_next  =
                        (rider_head_reg == nrd_pkg::RIDX_W'(nrd_pkg::RIDER_DEPTH - 1))
                        ? '0 : rider_head_reg + 1'b1;
                    rider_count_next = rider_count_reg - 1'b1;
                    scan_cnt_next    = '0;
                    best_clear       = 1'b1;
                    res_status_next  = nrd_pkg::STATUS_PAIRED;
                    state_next       = nrd_pkg::BK_SCAN;
                end
            end

            nrd_pkg::BK_SCAN:
            begin
                srv_raddr = scan_cnt_reg[nrd_pkg::SIDX_W-1:0];
                if (scan_cnt_reg < server_count_reg)
                begin
                    scan_issue    = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else if (!s1_valid_reg && !s2_valid_reg)
                begin
                    sh_idx_next = nrd_pkg::SCNT_W'(best_idx_reg) + 1'b1;
                    state_next  = nrd_pkg::BK_SHIFT;
                end
            end

            nrd_pkg::BK_SHIFT:
            begin
                // close the gap left by the matched server
                srv_raddr = sh_idx_reg[nrd_pkg::SIDX_W-1:0];
                if (sh_idx_reg < server_count_reg)
                begin
                    sh_issue    = 1'b1;
                    sh_idx_next = sh_idx_reg + 1'b1;
                end
                else if (!sh_w_valid_reg)
                begin
                    server_count_next = server_count_reg - 1'b1;
                    state_next        = nrd_pkg::BK_RESP;
                end
            end

            nrd_pkg::BK_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = nrd_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = nrd_pkg::BK_IDLE;
            end
        endcase

        if (sh_w_valid_reg)
        begin
            srv_we    = 1'b1;
            srv_waddr = sh_w_addr_reg;
            srv_wdata = srv_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= nrd_pkg::BK_IDLE;
            rider_head_reg   <= '0;
            rider_tail_reg   <= '0;
            rider_count_reg  <= '0;
            server_count_reg <= '0;
            scan_cnt_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            best_valid_reg   <= 1'b0;
            sh_idx_reg       <= '0;
            sh_w_valid_reg   <= 1'b0;
            res_status_reg   <= nrd_pkg::STATUS_STORED;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rider_head_reg   <= rider_head_next;
            rider_tail_reg   <= rider_tail_next;
            rider_count_reg  <= rider_count_next;
            server_count_reg <= server_count_next;
            scan_cnt_reg     <= scan_cnt_next;
            s1_valid_reg     <= scan_issue;
            s2_valid_reg     <= s1_valid_reg;
            sh_idx_reg       <= sh_idx_next;
            sh_w_valid_reg   <= sh_issue;
            res_status_reg   <= res_status_next;
            if (best_clear)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (s2_valid_reg)
            begin
                best_valid_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rider_we)
        begin
            rider_mem[rider_tail_reg] <= op.entry;
        end
        if (rider_rd_en)
        begin
            rider_reg <= rider_mem[rider_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (srv_we)
        begin
            srv_mem[srv_waddr] <= srv_wdata;
        end
        srv_rd_reg <= srv_mem[srv_raddr];
    end

    // ------------------------------------------------------------------
    // distance pipeline: read, square, add and compare
    // ------------------------------------------------------------------
    assign dx     = $signed({rider_reg.x[nrd_pkg::COORD_W-1], rider_reg.x})
                  - $signed({srv_rd_reg.x[nrd_pkg::COORD_W-1], srv_rd_reg.x});
    assign dy     = $signed({rider_reg.y[nrd_pkg::COORD_W-1], rider_reg.y})
                  - $signed({srv_rd_reg.y[nrd_pkg::COORD_W-1], srv_rd_reg.y});
    assign prod_x = dx * dx;
    assign prod_y = dy * dy;
    assign sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= srv_raddr;
        s2_idx_reg  <= s1_idx_reg;
        s2_conn_reg <= srv_rd_reg.conn;
        sqx_reg     <= prod_x[nrd_pkg::SQ_W-1:0];
        sqy_reg     <= prod_y[nrd_pkg::SQ_W-1:0];
        sh_w_addr_reg <= sh_prev[nrd_pkg::SIDX_W-1:0];
        // later slots are newer, so equal distance moves the pick forward
        if (s2_valid_reg && (!best_valid_reg || sq_sum <= best_d_reg))
        begin
            best_d_reg    <= sq_sum;
            best_idx_reg  <= s2_idx_reg;
            best_conn_reg <= s2_conn_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= res_status_reg;
            if (res_status_reg == nrd_pkg::STATUS_PAIRED)
            begin
                server_conn_reg <= best_conn_reg;
                rider_conn_reg  <= rider_reg.conn;
                rider_x_reg     <= rider_reg.x;
                rider_y_reg     <= rider_reg.y;
            end
            else
            begin
                server_conn_reg <= '0;
                rider_conn_reg  <= '0;
                rider_x_reg     <= '0;
                rider_y_reg     <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_one_store_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nrd_pkg::BK_IDLE |-> (rider_count_reg == '0 || server_count_reg == '0))
        else $error("both stores hold entries while idle");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rider_count_reg <= nrd_pkg::RCNT_W'(nrd_pkg::RIDER_DEPTH)
        && server_count_reg <= nrd_pkg::SCNT_W'(nrd_pkg::SERVER_SLOTS))
        else $error("store count beyond depth");

    a_shift_removes_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nrd_pkg::BK_SHIFT && state_next == nrd_pkg::BK_RESP)
        |=> server_count_reg == $past(server_count_reg) - nrd_pkg::SCNT_W'(1))
        else $error("matched server not removed");

    a_scan_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> state_reg == nrd_pkg::BK_SCAN)
        else $error("scan pipeline active outside scan");

    a_shift_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nrd_pkg::BK_SHIFT |-> best_valid_reg)
        else $error("compaction without a chosen server");

endmodule

/* hw/rtl/nearest_resource_dispatcher_unit.sv */
// A dropped item goes from BK_IDLE straight to BK_RESP, a stored one through BK_CHECK first;
// a pairing also runs the distance scan and then list compaction, each reading one server list
// entry per cycle, the scan over all N servers held; output stalls delay every result.
// One item executes at a time; the back end takes no new item until it is back in BK_IDLE,
// and a two-entry queue lets the input side run ahead.
// Reset (rst_n, asynchronous, active low) empties both stores; entries are not cleared.
// ----------------------------------------------------------------------------
// nearest_resource_dispatcher_unit
// Pairs the oldest waiting rider with the nearest free server, newest server
// winning ties.
// ----------------------------------------------------------------------------
module nearest_resource_dispatcher_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic signed [nrd_pkg::COORD_W-1:0] pos_x,
    input  logic signed [nrd_pkg::COORD_W-1:0] pos_y,
    input  logic [nrd_pkg::CONN_W-1:0]         conn_id,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [nrd_pkg::STATUS_W-1:0]       status,
    output logic [nrd_pkg::CONN_W-1:0]         server_conn,
    output logic [nrd_pkg::CONN_W-1:0]         rider_conn,
    output logic signed [nrd_pkg::COORD_W-1:0] rider_x,
    output logic signed [nrd_pkg::COORD_W-1:0] rider_y
);

    logic         fr_valid;
    logic         fr_ready;
    nrd_pkg::op_t fr_op;
    logic         bk_valid;
    logic         bk_ready;
    nrd_pkg::op_t bk_op;

    nrd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .conn_id  (conn_id),
        .op_valid (fr_valid),
        .op_ready (fr_ready),
        .op       (fr_op)
    );

    nrd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_op    (fr_op),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_op     (bk_op)
    );

    nrd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (bk_valid),
        .op_ready    (bk_ready),
        .op          (bk_op),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .server_conn (server_conn),
        .rider_conn  (rider_conn),
        .rider_x     (rider_x),
        .rider_y     (rider_y)
    );

endmodule
